FILE: rtl/ptsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsl_pkg: shared types and constants for the playback transport
// Command codes, play states, register indexes and reset values.
// ----------------------------------------------------------------------------
package ptsl_pkg;

  localparam int POS_W           = 40;           // tick field width
  localparam int MARK_W          = 41;           // in/out point registers
  localparam int TPF_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 41;
  localparam int TICK_BITS       = 40;
  localparam int MAX_SHUTTLE_DEF = 3;

  localparam logic [POS_W-1:0] TICK_MAX =
      POS_W'((64'(1) << TICK_BITS) - 64'(1));
  localparam logic [TPF_W-1:0]  FALLBACK_STEP = TPF_W'(2000);
  localparam logic [TPF_W-1:0]  TPF_RESET     = TPF_W'(2000);
  localparam logic [MARK_W-1:0] MARK_UNSET    = '1;

  typedef enum logic [3:0] {
    CMD_PLAY     = 4'd0,
    CMD_PAUSE    = 4'd1,
    CMD_TOGGLE   = 4'd2,
    CMD_STOP     = 4'd3,
    CMD_SEEK     = 4'd4,
    CMD_STEP_FWD = 4'd5,
    CMD_STEP_BK  = 4'd6,
    CMD_SHTL_REV = 4'd7,
    CMD_SHTL_FWD = 4'd8,
    CMD_START    = 4'd9,
    CMD_END      = 4'd10,
    CMD_GOTO_IN  = 4'd11,
    CMD_GOTO_OUT = 4'd12,
    CMD_ADVANCE  = 4'd13
  } cmd_e;

  typedef enum logic [1:0] {
    PS_STOPPED   = 2'd0,
    PS_PLAYING   = 2'd1,
    PS_PAUSED    = 2'd2,
    PS_SHUTTLING = 2'd3
  } pstate_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOOP_EN  = 3'd0,
    REG_IN_PT    = 3'd1,
    REG_OUT_PT   = 3'd2,
    REG_DURATION = 3'd3,
    REG_TPF      = 3'd4
  } reg_idx_e;

endpackage

FILE: rtl/playback_transport_shuttle_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playback_transport_shuttle_loop: media transport with shuttle and loop wrap
// Play state machine, playhead in 48 kHz ticks, JKL shuttle levels and
// loop wrap through an iterative remainder unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command beat: cmd_i and
//   value_i. Every beat yields exactly one result beat on the output channel
//   (out_valid_o/out_ready_i): position, play state, speed, changed flag.
//   Configuration registers are written through cfg_valid_i/cfg_index_i/
//   cfg_data_i; cfg_ready_o is always high. Write only while idle.
//   Each command runs execute then finish; a moving advance adds compare,
//   select and end states, and a wrap also runs a one-bit-per-cycle
//   restoring remainder in the divide states. One command is in work at a time.
//   The result sits in an output register: the next command is accepted while
//   it waits, and that command's result holds in its final state until the
//   receiver takes the earlier beat.
//   Reset: stopped, playhead 0, speed 0, marks unset, 2000 ticks per frame.
// ----------------------------------------------------------------------------
module playback_transport_shuttle_loop
  #(
    parameter int MAX_SHUTTLE_LEVEL = ptsl_pkg::MAX_SHUTTLE_DEF
  )
  (
    input  logic                              clk_i,
    input  logic                              rst_ni,
    // command channel
    input  logic                              in_valid_i,
    output logic                              in_ready_o,
    input  logic [3:0]                        cmd_i,
    input  logic [ptsl_pkg::POS_W-1:0]        value_i,
    // result channel
    output logic                              out_valid_o,
    input  logic                              out_ready_i,
    output logic [ptsl_pkg::POS_W-1:0]        position_o,
    output logic [1:0]                        play_state_o,
    output logic signed [3:0]                 speed_o,
    output logic                              position_changed_o,
    // configuration
    input  logic                              cfg_valid_i,
    output logic                              cfg_ready_o,
    input  logic [ptsl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
    input  logic [ptsl_pkg::CFG_DATA_W-1:0]   cfg_data_i
  );

  import ptsl_pkg::*;

  localparam int LVL_W = $clog2(MAX_SHUTTLE_LEVEL + 1);
  localparam int SH_W  = (MAX_SHUTTLE_LEVEL > 1) ? $clog2(MAX_SHUTTLE_LEVEL) : 1;
  localparam int SPD_W = MAX_SHUTTLE_LEVEL + 1;
  localparam int TW    = POS_W + MAX_SHUTTLE_LEVEL;  // advance sum width
  localparam int CNT_W = $clog2(TW);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_SHUTTLE_LEVEL);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ADV_CMP,
    S_ADV_SEL,
    S_DIV,
    S_DIV_END,
    S_ADV_END,
    S_FIN
  } seq_e;

  // configuration
  logic              loop_q;
  logic [MARK_W-1:0] in_pt_q;
  logic [MARK_W-1:0] out_pt_q;
  logic [POS_W-1:0]  dur_q;
  logic [TPF_W-1:0]  tpf_q;

  // transport state
  seq_e                    st_q;
  pstate_e                 pst_q;
  logic [POS_W-1:0]        ph_q;
  logic [POS_W-1:0]        last_q;
  logic [LVL_W-1:0]        rlvl_q;
  logic [LVL_W-1:0]        flvl_q;
  logic signed [SPD_W-1:0] speed_q;
  logic [SH_W-1:0]         sh_q;

  // command latch and advance datapath
  logic [3:0]        cmd_q;
  logic [POS_W-1:0]  val_q;
  logic [TW-1:0]     t_q;
  logic [POS_W-1:0]  ls_q;
  logic [POS_W-1:0]  le_q;      // loop end, then loop length during the divide
  logic [POS_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              wrap_q;
  logic              hi_q;
  logic              lo_q;

  // result register
  logic              out_valid_q;
  logic [POS_W-1:0]  pos_out_q;
  pstate_e           pst_out_q;
  logic signed [3:0] spd_out_q;
  logic              chg_out_q;

  // combinational helpers
  logic              moving;
  logic              rev;
  logic              in_set;
  logic              out_set;
  logic              pair_ok;
  logic [TPF_W-1:0]  step;
  logic [POS_W:0]    t_stepf;
  logic [POS_W-1:0]  t_stepb;
  logic [TW-1:0]     delta;
  logic [TW-1:0]     t_adv;
  logic [POS_W-1:0]  ls_n;
  logic [POS_W-1:0]  le_n;
  logic              seek_en;
  logic [POS_W-1:0]  seek_tgt;
  logic [LVL_W-1:0]  nrl;
  logic [LVL_W-1:0]  nfl;
  logic [SH_W-1:0]   nsh_r;
  logic [SH_W-1:0]   nsh_f;
  logic [POS_W:0]    rsh;
  logic [POS_W-1:0]  ph_sat;
  logic              done_ok;

  function automatic logic [POS_W-1:0] sat_tick(input logic [TW-1:0] t);
    logic [TW-1:0] hi_part;
    hi_part = t >> TICK_BITS;
    if (hi_part != '0) begin
      return TICK_MAX;
    end
    return t[POS_W-1:0];
  endfunction

  assign moving  = (pst_q == PS_PLAYING) || (pst_q == PS_SHUTTLING);
  assign rev     = speed_q[SPD_W-1];
  assign in_set  = !in_pt_q[MARK_W-1];
  assign out_set = !out_pt_q[MARK_W-1];
  assign pair_ok = in_set && out_set && (out_pt_q[POS_W-1:0] > in_pt_q[POS_W-1:0]);
  assign ls_n    = pair_ok ? in_pt_q[POS_W-1:0] : '0;
  assign le_n    = pair_ok ? out_pt_q[POS_W-1:0] : dur_q;

  assign step    = (tpf_q == '0) ? FALLBACK_STEP : tpf_q;
  assign t_stepb = ({{(POS_W-TPF_W){1'b0}}, step} >= ph_q) ? '0
                 : ph_q - {{(POS_W-TPF_W){1'b0}}, step};

  always_comb begin
    t_stepf = {1'b0, ph_q} + (POS_W+1)'(step);
    if ((dur_q != '0) && (t_stepf > {1'b0, dur_q})) begin
      t_stepf = {1'b0, dur_q};
    end
  end

  // speed magnitude is always a power of two: the multiply is a shift
  assign delta = TW'(val_q) << sh_q;
  assign t_adv = rev ? ((delta >= TW'(ph_q)) ? '0 : TW'(ph_q) - delta)
                     : TW'(ph_q) + delta;

  assign nrl   = (flvl_q != '0) ? LVL_W'(1)
               : ((rlvl_q == LVL_MAX) ? LVL_MAX : rlvl_q + LVL_W'(1));
  assign nfl   = (rlvl_q != '0) ? LVL_W'(1)
               : ((flvl_q == LVL_MAX) ? LVL_MAX : flvl_q + LVL_W'(1));
  assign nsh_r = SH_W'(nrl - LVL_W'(1));
  assign nsh_f = SH_W'(nfl - LVL_W'(1));

  always_comb begin
    seek_en  = 1'b0;
    seek_tgt = '0;
    case (cmd_q)
      CMD_SEEK: begin
        seek_en  = 1'b1;
        seek_tgt = val_q;
      end
      CMD_START: begin
        seek_en  = 1'b1;
      end
      CMD_END: begin
        seek_en  = 1'b1;
        seek_tgt = dur_q;
      end
      CMD_GOTO_IN: begin
        seek_en  = in_set;
        seek_tgt = in_pt_q[POS_W-1:0];
      end
      CMD_GOTO_OUT: begin
        seek_en  = out_set;
        seek_tgt = out_pt_q[POS_W-1:0];
      end
      default: begin
        seek_en  = 1'b0;
      end
    endcase
  end

  // remainder step: partial remainder with the next numerator bit shifted in
  assign rsh     = {rem_q, t_q[TW-1]};
  assign ph_sat  = sat_tick(t_q);
  assign done_ok = !out_valid_q || out_ready_i;

  assign in_ready_o  = (st_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q   <= 1'b0;
      in_pt_q  <= MARK_UNSET;
      out_pt_q <= MARK_UNSET;
      dur_q    <= '0;
      tpf_q    <= TPF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LOOP_EN:  loop_q   <= cfg_data_i[0];
        REG_IN_PT:    in_pt_q  <= cfg_data_i[MARK_W-1:0];
        REG_OUT_PT:   out_pt_q <= cfg_data_i[MARK_W-1:0];
        REG_DURATION: dur_q    <= cfg_data_i[POS_W-1:0];
        REG_TPF:      tpf_q    <= cfg_data_i[TPF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      pst_q       <= PS_STOPPED;
      ph_q        <= '0;
      last_q      <= '0;
      rlvl_q      <= '0;
      flvl_q      <= '0;
      speed_q     <= '0;
      sh_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result loaded in this cycle keeps the flag set
      if (out_valid_q && out_ready_i && !((st_q == S_FIN) && done_ok)) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= cmd_i;
            val_q <= value_i;
            st_q  <= S_EXEC;
          end
        end

        S_EXEC: begin
          if ((cmd_q == CMD_ADVANCE) && moving) begin
            st_q <= S_ADV_CMP;
          end else begin
            st_q <= S_FIN;
          end
          case (cmd_q)
            CMD_PLAY: begin
              if (pst_q != PS_PLAYING) begin
                pst_q   <= PS_PLAYING;
                speed_q <= SPD_W'(1);
                sh_q    <= '0;
                rlvl_q  <= '0;
                flvl_q  <= '0;
              end
            end
            CMD_PAUSE: begin
              if (moving) begin
                pst_q   <= PS_PAUSED;
                speed_q <= '0;
                rlvl_q  <= '0;
                flvl_q  <= '0;
              end
            end
            CMD_TOGGLE: begin
              rlvl_q <= '0;
              flvl_q <= '0;
              if (moving) begin
                pst_q   <= PS_PAUSED;
                speed_q <= '0;
              end else begin
                pst_q   <= PS_PLAYING;
                speed_q <= SPD_W'(1);
                sh_q    <= '0;
              end
            end
            CMD_STOP: begin
              pst_q   <= PS_STOPPED;
              speed_q <= '0;
              rlvl_q  <= '0;
              flvl_q  <= '0;
              ph_q    <= in_set ? sat_tick(TW'(in_pt_q[POS_W-1:0])) : '0;
            end
            CMD_SEEK, CMD_START, CMD_END, CMD_GOTO_IN, CMD_GOTO_OUT: begin
              if (seek_en) begin
                rlvl_q  <= '0;
                flvl_q  <= '0;
                speed_q <= (pst_q == PS_PLAYING) ? SPD_W'(1) : '0;
                sh_q    <= '0;
                if (pst_q == PS_SHUTTLING) begin
                  pst_q <= PS_PAUSED;
                end
                ph_q <= sat_tick(TW'(seek_tgt));
              end
            end
            CMD_STEP_FWD, CMD_STEP_BK: begin
              if (moving) begin
                pst_q   <= PS_PAUSED;
                speed_q <= '0;
                rlvl_q  <= '0;
                flvl_q  <= '0;
              end
              if (cmd_q == CMD_STEP_FWD) begin
                ph_q <= sat_tick(TW'(t_stepf));
              end else begin
                ph_q <= t_stepb;
              end
            end
            CMD_SHTL_REV: begin
              rlvl_q  <= nrl;
              flvl_q  <= '0;
              sh_q    <= nsh_r;
              speed_q <= -(SPD_W'(1) << nsh_r);
              pst_q   <= PS_SHUTTLING;
            end
            CMD_SHTL_FWD: begin
              flvl_q  <= nfl;
              rlvl_q  <= '0;
              sh_q    <= nsh_f;
              speed_q <= SPD_W'(1) << nsh_f;
              pst_q   <= PS_SHUTTLING;
            end
            CMD_ADVANCE: begin
              if (moving) begin
                t_q  <= t_adv;
                ls_q <= ls_n;
                le_q <= le_n;
              end
            end
            default: begin
            end
          endcase
        end

        S_ADV_CMP: begin
          wrap_q <= loop_q && (le_q > ls_q);
          hi_q   <= t_q >= TW'(le_q);
          lo_q   <= t_q < TW'(ls_q);
          st_q   <= S_ADV_SEL;
        end

        S_ADV_SEL: begin
          if (wrap_q && hi_q) begin
            t_q   <= t_q - TW'(ls_q);
            le_q  <= le_q - ls_q;
            rem_q <= '0;
            cnt_q <= CNT_W'(TW - 1);
            st_q  <= S_DIV;
          end else begin
            if (wrap_q && lo_q && rev) begin
              t_q <= TW'(le_q);
            end
            st_q <= S_ADV_END;
          end
        end

        // restoring remainder, one numerator bit per cycle
        S_DIV: begin
          if (rsh >= {1'b0, le_q}) begin
            rem_q <= POS_W'(rsh - {1'b0, le_q});
          end else begin
            rem_q <= rsh[POS_W-1:0];
          end
          t_q <= t_q << 1;
          if (cnt_q == '0) begin
            st_q <= S_DIV_END;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end

        S_DIV_END: begin
          t_q  <= TW'(ls_q) + TW'(rem_q);
          st_q <= S_ADV_END;
        end

        S_ADV_END: begin
          ph_q <= ph_sat;
          if (!loop_q &&
              (((pst_q == PS_PLAYING) && (dur_q != '0) && (ph_sat >= dur_q)) ||
               ((pst_q == PS_SHUTTLING) && rev && (ph_sat == '0)))) begin
            pst_q   <= PS_PAUSED;
            speed_q <= '0;
            rlvl_q  <= '0;
            flvl_q  <= '0;
          end
          st_q <= S_FIN;
        end

        S_FIN: begin
          if (done_ok) begin
            out_valid_q <= 1'b1;
            pos_out_q   <= ph_q;
            pst_out_q   <= pst_q;
            spd_out_q   <= 4'(speed_q);
            chg_out_q   <= (ph_q != last_q);
            last_q      <= ph_q;
            st_q        <= S_IDLE;
          end
        end

        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign position_o         = pos_out_q;
  assign play_state_o       = pst_out_q;
  assign speed_o            = spd_out_q;
  assign position_changed_o = chg_out_q;

  // divisor is the loop length, never zero while dividing
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (le_q != '0))
    else $error("loop length zero during remainder");

  // partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (rem_q < le_q))
    else $error("remainder out of range");

  // halted states report zero speed
  a_halt_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((play_state_o == PS_STOPPED) || (play_state_o == PS_PAUSED)))
      |-> (speed_o == '0))
    else $error("nonzero speed while halted");

  // one command in work at a time
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("command accepted while busy");

endmodule

FILE: verif/ptsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsl_checker: scoreboard for the playback transport
// Watches the command, result and register channels, keeps its own copy of
// the transport state and registers, predicts one result per command beat
// and compares every result beat field by field, oldest first.
// ----------------------------------------------------------------------------
module ptsl_checker
  (
    input  logic                              clk_i,
    input  logic                              rst_ni,
    input  logic                              in_valid_i,
    input  logic                              in_ready_i,
    input  logic [3:0]                        cmd_i,
    input  logic [ptsl_pkg::POS_W-1:0]        value_i,
    input  logic                              out_valid_i,
    input  logic                              out_ready_i,
    input  logic [ptsl_pkg::POS_W-1:0]        position_i,
    input  logic [1:0]                        play_state_i,
    input  logic [3:0]                        speed_i,
    input  logic                              position_changed_i,
    input  logic                              cfg_valid_i,
    input  logic                              cfg_ready_i,
    input  logic [ptsl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
    input  logic [ptsl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
    output int                                fail_count_o,
    output int                                pending_o
  );

  import ptsl_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [1:0]       play_state;
    logic [3:0]       speed;
    logic             changed;
  } transport_result_t;

  localparam logic [63:0] TICK_LIMIT = 64'(TICK_MAX);

  // registers as seen by the block
  logic              loop_en;
  logic [MARK_W-1:0] in_pt;
  logic [MARK_W-1:0] out_pt;
  logic [POS_W-1:0]  dur;
  logic [TPF_W-1:0]  tpf;

  // transport state
  pstate_e           tstate;
  logic [POS_W-1:0]  head;
  logic [POS_W-1:0]  last_pos;
  int unsigned       rev_lvl;
  int unsigned       fwd_lvl;
  int                spd;

  transport_result_t result_q[$];
  transport_result_t want;
  int                fails;

  function automatic logic [63:0] clamp_tick(input logic [63:0] t);
    return (t > TICK_LIMIT) ? TICK_LIMIT : t;
  endfunction

  function automatic int unsigned bump_level(input int unsigned lvl);
    return (lvl + 1 > MAX_SHUTTLE_DEF) ? MAX_SHUTTLE_DEF : lvl + 1;
  endfunction

  function automatic logic moving();
    return tstate == PS_PLAYING || tstate == PS_SHUTTLING;
  endfunction

  task automatic halt_transport();
    if (!moving()) return;
    spd     = 0;
    rev_lvl = 0;
    fwd_lvl = 0;
    tstate  = PS_PAUSED;
  endtask

  task automatic start_play();
    if (tstate == PS_PLAYING) return;
    spd     = 1;
    rev_lvl = 0;
    fwd_lvl = 0;
    tstate  = PS_PLAYING;
  endtask

  task automatic jump_to(input logic [63:0] t);
    rev_lvl = 0;
    fwd_lvl = 0;
    if (tstate == PS_SHUTTLING) tstate = PS_PAUSED;
    spd  = (tstate == PS_PLAYING) ? 1 : 0;
    head = POS_W'(clamp_tick(t));
  endtask

  task automatic advance_head(input logic [POS_W-1:0] elapsed);
    logic        rev;
    logic [63:0] mag, delta, t, ls, le;
    if (!moving()) return;
    rev   = spd < 0;
    mag   = rev ? 64'(-spd) : 64'(spd);
    delta = 64'(elapsed) * mag;
    if (rev) t = (delta >= 64'(head)) ? 64'd0 : 64'(head) - delta;
    else     t = 64'(head) + delta;
    if (loop_en) begin
      ls = 64'd0;
      le = 64'(dur);
      // marks only bound the loop when both are set and ordered
      if (!in_pt[POS_W] && !out_pt[POS_W] && out_pt[POS_W-1:0] > in_pt[POS_W-1:0]) begin
        ls = 64'(in_pt[POS_W-1:0]);
        le = 64'(out_pt[POS_W-1:0]);
      end
      if (le > ls) begin
        if (t >= le) t = ls + (t - ls) % (le - ls);
        else if (t < ls && rev) t = le;
      end
    end
    head = POS_W'(clamp_tick(t));
    if (tstate == PS_PLAYING && !loop_en && dur != 0 && head >= dur) halt_transport();
    if (tstate == PS_SHUTTLING && rev && !loop_en && head == 0) halt_transport();
  endtask

  task automatic run_command(input logic [3:0] cmd, input logic [POS_W-1:0] value);
    logic [63:0] step, t;
    step = (tpf == 0) ? 64'(FALLBACK_STEP) : 64'(tpf);
    case (cmd)
      CMD_PLAY:   start_play();
      CMD_PAUSE:  halt_transport();
      CMD_TOGGLE: begin
        if (moving()) halt_transport();
        else start_play();
      end
      CMD_STOP: begin
        spd     = 0;
        rev_lvl = 0;
        fwd_lvl = 0;
        head    = in_pt[POS_W] ? '0 : in_pt[POS_W-1:0];
        tstate  = PS_STOPPED;
      end
      CMD_SEEK: jump_to(64'(value));
      CMD_STEP_FWD: begin
        halt_transport();
        t = 64'(head) + step;
        if (dur != 0 && t > 64'(dur)) t = 64'(dur);
        head = POS_W'(clamp_tick(t));
      end
      CMD_STEP_BK: begin
        halt_transport();
        head = (step >= 64'(head)) ? '0 : POS_W'(64'(head) - step);
      end
      CMD_SHTL_REV: begin
        if (fwd_lvl > 0) begin
          fwd_lvl = 0;
          rev_lvl = 0;
        end
        rev_lvl = bump_level(rev_lvl);
        spd     = -(1 << (rev_lvl - 1));
        tstate  = PS_SHUTTLING;
      end
      CMD_SHTL_FWD: begin
        if (rev_lvl > 0) begin
          rev_lvl = 0;
          fwd_lvl = 0;
        end
        fwd_lvl = bump_level(fwd_lvl);
        spd     = 1 << (fwd_lvl - 1);
        tstate  = PS_SHUTTLING;
      end
      CMD_START:    jump_to(64'd0);
      CMD_END:      jump_to(64'(dur));
      CMD_GOTO_IN:  if (!in_pt[POS_W]) jump_to(64'(in_pt[POS_W-1:0]));
      CMD_GOTO_OUT: if (!out_pt[POS_W]) jump_to(64'(out_pt[POS_W-1:0]));
      CMD_ADVANCE:  advance_head(value);
      default: ;
    endcase
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LOOP_EN:  loop_en = data[0];
      REG_IN_PT:    in_pt   = data[MARK_W-1:0];
      REG_OUT_PT:   out_pt  = data[MARK_W-1:0];
      REG_DURATION: dur     = data[POS_W-1:0];
      REG_TPF:      tpf     = data[TPF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
    $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, exp_v, act_v);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_en  = 1'b0;
      in_pt    = MARK_UNSET;
      out_pt   = MARK_UNSET;
      dur      = '0;
      tpf      = TPF_RESET;
      tstate   = PS_STOPPED;
      head     = '0;
      last_pos = '0;
      rev_lvl  = 0;
      fwd_lvl  = 0;
      spd      = 0;
      fails    = 0;
      result_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, position 0x%0h", $time,
                   position_i);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (position_i !== want.position)
            report_mismatch("position", 64'(want.position), 64'(position_i));
          if (play_state_i !== want.play_state)
            report_mismatch("play_state", 64'(want.play_state), 64'(play_state_i));
          if (speed_i !== want.speed)
            report_mismatch("speed", 64'(want.speed), 64'(speed_i));
          if (position_changed_i !== want.changed)
            report_mismatch("position_changed", 64'(want.changed), 64'(position_changed_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        run_command(cmd_i, value_i);
        want.position   = head;
        want.play_state = tstate;
        want.speed      = 4'(spd);
        want.changed    = head != last_pos;
        last_pos        = head;
        result_q.push_back(want);
      end
      fail_count_o <= fails;
      pending_o    <= result_q.size();
    end
  end

endmodule

FILE: verif/playback_transport_shuttle_loop_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playback_transport_shuttle_loop_tb: regression for the playback transport
// Directed commands for the corner cases, then phases of random command
// runs (play and shuttle runs with advances, plus noise) under a range of
// register settings, with bursty input, a stalling receiver and long holds.
// ----------------------------------------------------------------------------
module playback_transport_shuttle_loop_tb;

  import ptsl_pkg::*;

  localparam int          NUM_PHASES    = 9;
  localparam int          PHASE_ITEMS   = 125;
  localparam int          SETTLE_CYCLES = 60;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam logic [3:0]  CMD_UNUSED_LO = 4'd14;
  localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;

  typedef struct {
    logic              wrap_en;
    logic [MARK_W-1:0] in_pt;
    logic [MARK_W-1:0] out_pt;
    logic [POS_W-1:0]  dur;
    logic [TPF_W-1:0]  tpf;
  } transport_setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [3:0]            cmd = '0;
  logic [POS_W-1:0]      value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [POS_W-1:0]      position;
  logic [1:0]            play_state;
  logic signed [3:0]     speed;
  logic                  position_changed;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  int                    cycle_count = 0;
  int                    burst_left = 0;
  int                    hold_reqs = 0;
  int                    hold_served = 0;
  int                    hold_left = 0;
  int                    stall_mode = 0;
  int                    mode_left = 0;

  playback_transport_shuttle_loop u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .cmd_i              (cmd),
    .value_i            (value),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .position_o         (position),
    .play_state_o       (play_state),
    .speed_o            (speed),
    .position_changed_o (position_changed),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  ptsl_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .cmd_i              (cmd),
    .value_i            (value),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .position_i         (position),
    .play_state_i       (play_state),
    .speed_i            (speed),
    .position_changed_i (position_changed),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: long holds on request, otherwise random stall modes
  always @(posedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(5, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [POS_W-1:0] rand40();
    return POS_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [63:0] rand_below(input logic [63:0] bound);
    if (bound == 0) return 64'd0;
    return {$urandom(), $urandom()} % bound;
  endfunction

  // leaves the beat on the bus at the accepting edge; bursts end in a gap or, at random, run straight on
  task automatic send_cmd(input logic [3:0] c, input logic [POS_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input transport_setting_t s);
    cfg_write(REG_LOOP_EN, CFG_DATA_W'(s.wrap_en));
    cfg_write(REG_IN_PT, s.in_pt);
    cfg_write(REG_OUT_PT, s.out_pt);
    cfg_write(REG_DURATION, CFG_DATA_W'(s.dur));
    cfg_write(REG_TPF, CFG_DATA_W'(s.tpf));
    cfg_valid <= 1'b0;
  endtask

  // sender pauses until every result is back, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic transport_setting_t pick_setting(input int phase);
    transport_setting_t s;
    case (phase)
      0: s = '{1'b0, MARK_UNSET, MARK_UNSET, '0, TPF_RESET};
      1: s = '{1'b1, MARK_UNSET, MARK_UNSET, 40'd480000, 16'd1600};
      2: s = '{1'b1, 41'd2000, 41'd30000, 40'd50000, 16'd1};
      3: s = '{1'b0, 41'd5000, {1'b1, 40'h00_0000_0123}, 40'd100000, 16'd48000};
      4: s = '{1'b1, 41'd40000, 41'd10000, 40'd60000, 16'd0};
      5: s = '{1'b1, {1'b0, 40'hFF_FFFF_FFFE}, {1'b0, TICK_MAX}, TICK_MAX, 16'hFFFF};
      6: s = '{1'b1, 41'd0, 41'd1, 40'd1, 16'd1};
      default: begin
        s.wrap_en = 1'($urandom_range(0, 1));
        s.dur     = ($urandom_range(0, 3) == 0) ? rand40() : POS_W'(rand_below(2000000));
        s.in_pt   = ($urandom_range(0, 3) == 0) ? {1'b1, rand40()}
                                                : {1'b0, POS_W'(rand_below(64'(s.dur) + 1))};
        s.out_pt  = ($urandom_range(0, 3) == 0) ? {1'b1, rand40()}
                                                : {1'b0, POS_W'(rand_below(64'(s.dur) + 1))};
        s.tpf     = TPF_W'($urandom());
      end
    endcase
    return s;
  endfunction

  function automatic logic [POS_W-1:0] pick_elapsed(input logic [63:0] scale);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return rand40();
      2:       return POS_W'(scale);
      default: return POS_W'(rand_below(scale / 8 + 2));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_target(input logic [63:0] scale);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return TICK_MAX;
      2:       return rand40();
      default: return POS_W'(rand_below(scale + 1));
    endcase
  endfunction

  task automatic drive_phase(input logic [POS_W-1:0] span, input int quota);
    int          sent;
    int          runs;
    int          presses;
    logic [3:0]  c;
    logic [63:0] scale;
    sent  = 0;
    scale = (span != 0) ? 64'(span) : 64'd2000000;
    while (sent < quota) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 1) == 0) begin
            send_cmd(CMD_SEEK, POS_W'(rand_below(scale)));
            sent++;
          end
          send_cmd(($urandom_range(0, 3) == 0) ? CMD_TOGGLE : CMD_PLAY, rand40());
          runs = $urandom_range(2, 10);
          repeat (runs) send_cmd(CMD_ADVANCE, pick_elapsed(scale));
          sent += runs + 1;
        end
        4, 5, 6: begin
          presses = $urandom_range(1, 4);
          repeat (presses)
            send_cmd(($urandom_range(0, 3) == 0) ? CMD_SHTL_FWD : CMD_SHTL_REV, rand40());
          if ($urandom_range(0, 1) == 0) begin
            send_cmd(CMD_SHTL_FWD, rand40());
            presses++;
          end
          runs = $urandom_range(2, 10);
          repeat (runs) send_cmd(CMD_ADVANCE, pick_elapsed(scale));
          sent += presses + runs;
        end
        default: begin
          c = 4'($urandom_range(0, 15));
          send_cmd(c, (c == CMD_ADVANCE) ? pick_elapsed(scale) : pick_target(scale));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    transport_setting_t s;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: marks unset, empty timeline
    send_cmd(CMD_GOTO_IN, '0);
    send_cmd(CMD_GOTO_OUT, TICK_MAX);
    send_cmd(CMD_END, '0);
    send_cmd(CMD_ADVANCE, TICK_MAX);
    send_cmd(CMD_PLAY, '0);
    send_cmd(CMD_ADVANCE, TICK_MAX);
    repeat (4) send_cmd(CMD_SHTL_FWD, '0);
    send_cmd(CMD_ADVANCE, 40'd5);
    send_cmd(CMD_SEEK, 40'hFF_FFFF_FFFE);
    send_cmd(CMD_STEP_FWD, '0);
    send_cmd(CMD_UNUSED_LO, TICK_MAX);
    send_cmd(CMD_UNUSED_HI, '0);
    repeat (4) send_cmd(CMD_SHTL_REV, '0);
    send_cmd(CMD_ADVANCE, TICK_MAX);
    send_cmd(CMD_TOGGLE, '0);
    send_cmd(CMD_PAUSE, '0);
    drain();

    // loop between marks, zero frame size
    apply_setting('{1'b1, 41'd1000, 41'd5000, 40'd10000, 16'd0});
    send_cmd(CMD_STEP_FWD, '0);
    send_cmd(CMD_STEP_BK, '0);
    send_cmd(CMD_STEP_FWD, '0);
    send_cmd(CMD_SHTL_REV, '0);
    send_cmd(CMD_ADVANCE, 40'd1500);
    send_cmd(CMD_PLAY, '0);
    send_cmd(CMD_ADVANCE, 40'd7777);
    send_cmd(CMD_SEEK, 40'd3);
    send_cmd(CMD_GOTO_OUT, '0);
    send_cmd(CMD_START, '0);
    send_cmd(CMD_STOP, '0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      s = pick_setting(p);
      apply_setting(s);
      if (p == 2 || p == 6) hold_reqs <= hold_reqs + 1;
      drive_phase(s.dur, PHASE_ITEMS);
      drain();
    end

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
